@@ hdl/xxtea_pkg.sv @@
// Shared types, constants and helper functions for the zero-key five-word XXTEA pipeline.
`timescale 1ns / 1ps
`default_nettype none

package xxtea_pkg;

   localparam int BLOCK_WORDS = 5;
   localparam int CYCLE_COUNT = 6;
   localparam int CELL_COUNT  = BLOCK_WORDS * CYCLE_COUNT;
   localparam int POS_W       = $clog2(BLOCK_WORDS);

   typedef logic [31:0]                 word_type;
   typedef word_type [BLOCK_WORDS-1:0]  block_type;
   typedef logic [POS_W-1:0]            pos_type;

   localparam word_type DELTA       = 32'h9e3779b9;
   localparam word_type DECRYPT_SUM = 32'(CYCLE_COUNT * 64'(DELTA));

   localparam logic KIND_ENCRYPT = 1'b0;
   localparam logic KIND_DECRYPT = 1'b1;

   localparam pos_type POS_FIRST = '0;
   localparam pos_type POS_LAST  = POS_W'(BLOCK_WORDS - 1);

   // Data handed from one cell to the next.
   typedef struct packed {
      logic      kind;
      pos_type   pos;
      word_type  sum;
      block_type words;
   } stage_type;

   function automatic word_type mix(word_type y, word_type z, word_type sum);
      return (((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4))) ^ ((sum ^ y) + z);
   endfunction

   function automatic pos_type pos_succ(pos_type pos);
      return (pos == POS_LAST) ? POS_FIRST : pos + pos_type'(1);
   endfunction

   function automatic pos_type pos_pred(pos_type pos);
      return (pos == POS_FIRST) ? POS_LAST : pos - pos_type'(1);
   endfunction

   function automatic word_type pick(block_type blk, pos_type pos);
      word_type w;
      w = '0;
      for (int i = 0; i < BLOCK_WORDS; i++) begin
         if (pos == POS_W'(i)) begin
            w = blk[i];
         end
      end
      return w;
   endfunction

endpackage

`default_nettype wire

@@ hdl/xxtea_zero_key_five_word_cipher.sv @@
// Zero-key XXTEA cipher on five-word blocks: top level with the chain of update cells.
//
// A block is taken on every clock edge where start is high and busy is low; busy is high
// only while reset is held, so outside reset one block per cycle is accepted indefinitely.
// Each of the 30 word updates (six passes over five words) has its own cell with a
// register behind it, so every block runs through every cell register and comes out on the
// rsp_ ports in order, marked by rsp_valid for a single cycle. The receiver cannot
// stall: a result must be taken in the cycle it shows.
`timescale 1ns / 1ps
`default_nettype none

module xxtea_zero_key_five_word_cipher (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic                    req_kind,
   input  wire xxtea_pkg::word_type     req_word_0,
   input  wire xxtea_pkg::word_type     req_word_1,
   input  wire xxtea_pkg::word_type     req_word_2,
   input  wire xxtea_pkg::word_type     req_word_3,
   input  wire xxtea_pkg::word_type     req_word_4,
   output logic                         rsp_valid,
   output xxtea_pkg::word_type          rsp_out_0,
   output xxtea_pkg::word_type          rsp_out_1,
   output xxtea_pkg::word_type          rsp_out_2,
   output xxtea_pkg::word_type          rsp_out_3,
   output xxtea_pkg::word_type          rsp_out_4
);
   import xxtea_pkg::*;

   stage_type              chain [CELL_COUNT+1];
   logic [CELL_COUNT:0]    valid_chain;

   // Refuse transfers while reset clears the chain.
   assign busy = reset;

   // Seed the first cell with the start position and running sum for the direction.
   always_comb begin
      chain[0].kind     = req_kind;
      chain[0].pos      = (req_kind == KIND_DECRYPT) ? POS_LAST : POS_FIRST;
      chain[0].sum      = (req_kind == KIND_DECRYPT) ? DECRYPT_SUM : DELTA;
      chain[0].words[0] = req_word_0;
      chain[0].words[1] = req_word_1;
      chain[0].words[2] = req_word_2;
      chain[0].words[3] = req_word_3;
      chain[0].words[4] = req_word_4;
   end

   assign valid_chain[0] = start & ~busy;

   for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
      xxtea_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .valid_i (valid_chain[g]),
         .data_i  (chain[g]),
         .valid_o (valid_chain[g+1]),
         .data_o  (chain[g+1])
      );
   end

   assign rsp_valid = valid_chain[CELL_COUNT];
   assign rsp_out_0 = chain[CELL_COUNT].words[0];
   assign rsp_out_1 = chain[CELL_COUNT].words[1];
   assign rsp_out_2 = chain[CELL_COUNT].words[2];
   assign rsp_out_3 = chain[CELL_COUNT].words[3];
   assign rsp_out_4 = chain[CELL_COUNT].words[4];

   // Every transfer yields a result after the full chain.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##30 rsp_valid)
      else $error("accepted block did not emerge after 30 cycles");

   // No result without a matching earlier transfer at the head of the chain.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 30))
      else $error("result strobe without a matching transfer");

   // After whole passes the position is back where the direction began.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((chain[CELL_COUNT].kind == KIND_DECRYPT && chain[CELL_COUNT].pos == POS_LAST)
                  || (chain[CELL_COUNT].kind == KIND_ENCRYPT
                      && chain[CELL_COUNT].pos == POS_FIRST)))
      else $error("word position out of step at the end of the chain");

endmodule

`default_nettype wire

@@ hdl/xxtea_cell.sv @@
// One pipeline cell: applies a single XXTEA word update and registers the block.
`timescale 1ns / 1ps
`default_nettype none

module xxtea_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 valid_i,
   input  wire xxtea_pkg::stage_type data_i,
   output logic                      valid_o,
   output xxtea_pkg::stage_type      data_o
);
   import xxtea_pkg::*;

   logic      valid_ff;
   stage_type data_ff;
   stage_type data_in;
   word_type  y_word;
   word_type  z_word;
   word_type  cur_word;
   word_type  mix_word;
   word_type  new_word;

   always_comb begin
      y_word   = pick(data_i.words, pos_succ(data_i.pos));
      z_word   = pick(data_i.words, pos_pred(data_i.pos));
      cur_word = pick(data_i.words, data_i.pos);
      mix_word = mix(y_word, z_word, data_i.sum);
      new_word = (data_i.kind == KIND_DECRYPT) ? cur_word - mix_word : cur_word + mix_word;

      data_in = data_i;
      for (int i = 0; i < BLOCK_WORDS; i++) begin
         if (data_i.pos == POS_W'(i)) begin
            data_in.words[i] = new_word;
         end
      end

      // Advance the position; step the running sum once a full pass is done.
      if (data_i.kind == KIND_DECRYPT) begin
         data_in.pos = pos_pred(data_i.pos);
         if (data_i.pos == POS_FIRST) begin
            data_in.sum = data_i.sum - DELTA;
         end
      end else begin
         data_in.pos = pos_succ(data_i.pos);
         if (data_i.pos == POS_LAST) begin
            data_in.sum = data_i.sum + DELTA;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid_o = valid_ff;
   assign data_o  = data_ff;

endmodule

`default_nettype wire
